/* hdl/cpe_pkg.sv */
// Shared types and constants for the characteristic polynomial engine.
package cpe_pkg;
    localparam int MaxOrder = 8;
    localparam int CoefW = 64;
    localparam int ElemW = 32;
    localparam logic signed [63:0] Q32One = 64'sh0000_0001_0000_0000;
    localparam logic signed [63:0] S64Max = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64Min = 64'sh8000_0000_0000_0000;

    typedef enum logic [3:0] {
        ST_LOAD, ST_INIT, ST_MREAD, ST_MMUL, ST_MHI, ST_MACC, ST_PWR,
        ST_DIVI, ST_DIV, ST_DIAG, ST_EMIT
    } cpe_state_t;

    function automatic logic signed [63:0] sat64(input logic signed [127:0] v);
        if (v > 128'sh7FFF_FFFF_FFFF_FFFF) return S64Max;
        if (v < -128'sh8000_0000_0000_0000) return S64Min;
        return v[63:0];
    endfunction
endpackage

/* hdl/characteristic_polynomial_engine_unit.sv */
// Top level: Faddeev-LeVerrier characteristic polynomial engine.
// Load transactions are accepted back to back. The last transaction starts the recursion.
// Recursion: identity setup, then per step k a matrix product on one shared 33x33 multiplier
// used twice per product, the trace, a one-bit-per-cycle divider and the diagonal update.
// Then n+1 coefficients, one per cycle when m_tready is high; no load meanwhile.
// Reset (aresetn low, synchronous) returns to loading with order 1.
module characteristic_polynomial_engine_unit
    import cpe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // elem_row[2:0], elem_col[5:3], elem_value[37:6], pad
    input  logic        s_tlast,  // load_done
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // coeff_index[3:0], coeff_value[67:4], pad
    output logic        m_tlast   // coeff_last
);
    localparam int AW = $clog2(MaxOrder);
    localparam int MW = 2 * AW;
    localparam int DEPTH = MaxOrder * MaxOrder;
    localparam int KW = $clog2(MaxOrder + 1);
    localparam logic [KW-1:0] MaxN = KW'(MaxOrder);

    cpe_state_t state_reg, state_next;
    logic [3:0] order_reg;
    logic [KW-1:0] n_reg, k_reg, i_reg, j_reg, l_reg, p_reg;
    logic signed [127:0] acc_reg, trace_reg;
    logic signed [65:0] prod_reg;
    logic [127:0] num_reg, rem_reg;
    logic [6:0] bit_reg;
    logic neg_reg;
    logic signed [63:0] c_reg;
    logic signed [63:0] coeff_reg [MaxOrder+1];
    logic [KW-1:0] init_i;

    // DIAG: l_reg=0 primes read; then i_reg/j_reg address read, write uses prev address regs
    logic [KW-1:0] di_reg, dj_reg;

    logic [2:0] s_row, s_col;
    assign s_row = s_tdata[2:0];
    assign s_col = s_tdata[5:3];

    logic a_we, w_we, p_we;
    logic [MW-1:0] a_wa, a_ra, w_wa, w_ra, p_wa, p_ra;
    logic [ElemW-1:0] a_rd;
    logic [CoefW-1:0] w_wd, w_rd, p_wd, p_rd;

    cpe_ram #(.WIDTH(ElemW), .DEPTH(DEPTH)) u_a (.aclk, .we(a_we), .waddr(a_wa),
        .wdata(s_tdata[37:6]), .raddr(a_ra), .rdata(a_rd));
    cpe_ram #(.WIDTH(CoefW), .DEPTH(DEPTH)) u_w (.aclk, .we(w_we), .waddr(w_wa),
        .wdata(w_wd), .raddr(w_ra), .rdata(w_rd));
    cpe_ram #(.WIDTH(CoefW), .DEPTH(DEPTH)) u_p (.aclk, .we(p_we), .waddr(p_wa),
        .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

    function automatic logic [MW-1:0] addr(input logic [KW-1:0] r, input logic [KW-1:0] c);
        return {r[AW-1:0], c[AW-1:0]};
    endfunction

    logic in_range;
    assign in_range = ({1'b0, s_row} < 4'(MaxOrder)) && ({1'b0, s_col} < 4'(MaxOrder));
    assign s_tready = (state_reg == ST_LOAD);
    assign cfg_ready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tlast = (p_reg == n_reg);
    assign m_tdata = {4'd0, coeff_reg[p_reg], 4'(p_reg)};

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_out;
    assign mul_a = {a_rd[31], a_rd};
    assign mul_b = (state_reg == ST_MHI) ? {w_rd[63], w_rd[63:32]} : {1'b0, w_rd[31:0]};
    assign mul_out = mul_a * mul_b;

    logic signed [127:0] prod_hi, acc_fin, pv_round, diag_sum;
    logic signed [63:0] c_new;
    logic [127:0] trial;
    assign prod_hi = 128'(prod_reg) <<< 32;
    assign acc_fin = acc_reg + prod_hi + 128'sd32768;
    assign pv_round = acc_fin >>> 16;
    assign diag_sum = 128'(signed'(p_rd)) + 128'(c_reg);
    assign trial = {rem_reg[126:0], num_reg[127]} - 128'(k_reg);
    assign c_new = neg_reg ? sat64(signed'(num_reg)) : sat64(-signed'(num_reg));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: if (s_tvalid && s_tlast) state_next = ST_INIT;
            ST_INIT: if (i_reg == n_reg - 1'b1 && j_reg == n_reg - 1'b1) state_next = ST_MREAD;
            ST_MREAD: state_next = ST_MMUL;
            ST_MMUL: state_next = ST_MHI;
            ST_MHI: state_next = ST_MACC;
            ST_MACC: begin
                if (l_reg == n_reg) begin
                    if (i_reg == n_reg - 1'b1 && j_reg == n_reg - 1'b1) state_next = ST_PWR;
                    else state_next = ST_MREAD;
                end else state_next = ST_MREAD;
            end
            ST_PWR: state_next = ST_DIVI;
            ST_DIVI: state_next = ST_DIV;
            ST_DIV: if (bit_reg == 7'd127) state_next = ST_DIAG;
            ST_DIAG: if (i_reg == n_reg && k_reg == n_reg) state_next = ST_EMIT;
                     else if (i_reg == n_reg) state_next = ST_MREAD;
            ST_EMIT: if (m_tready && p_reg == n_reg) state_next = ST_LOAD;
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        a_we = (state_reg == ST_LOAD) && s_tvalid && in_range;
        a_wa = {s_row[AW-1:0], s_col[AW-1:0]};
        init_i = i_reg;
        a_ra = addr(i_reg, l_reg);
        w_ra = addr(l_reg, j_reg);
        w_we = 1'b0;
        w_wa = addr(i_reg, j_reg);
        w_wd = (i_reg == j_reg) ? Q32One : '0;
        p_we = 1'b0;
        p_wa = addr(i_reg, j_reg);
        p_wd = sat64(pv_round);
        p_ra = addr(i_reg, i_reg);
        case (state_reg)
            ST_INIT: w_we = 1'b1;
            ST_MACC: p_we = (l_reg == n_reg);
            ST_DIAG: begin
                p_ra = addr(init_i, j_reg);
            end
            default: ;
        endcase
        if (state_reg == ST_DIAG && l_reg != 0) begin
            w_we = 1'b1;
            w_wa = addr(di_reg, dj_reg);
            w_wd = (di_reg == dj_reg) ? sat64(diag_sum) : p_rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            order_reg <= 4'd1;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) order_reg <= cfg_data;
        end
        prod_reg <= mul_out;
        di_reg <= i_reg;
        dj_reg <= j_reg;
        case (state_reg)
            ST_LOAD: begin
                n_reg <= (order_reg == 0) ? KW'(1) :
                         ({1'b0, order_reg} > 5'(MaxOrder)) ? MaxN : KW'(order_reg);
                i_reg <= '0; j_reg <= '0; l_reg <= '0; k_reg <= KW'(1); p_reg <= '0;
                acc_reg <= '0; trace_reg <= '0;
            end
            ST_INIT: begin
                if (j_reg == n_reg - 1'b1) begin
                    j_reg <= '0;
                    i_reg <= (i_reg == n_reg - 1'b1) ? '0 : i_reg + 1'b1;
                end else j_reg <= j_reg + 1'b1;
                coeff_reg[n_reg] <= Q32One;
            end
            ST_MREAD: ;
            ST_MMUL: ;
            ST_MHI: begin
                acc_reg <= acc_reg + 128'(prod_reg);
                l_reg <= l_reg + 1'b1;
            end
            ST_MACC: begin
                if (l_reg == n_reg) begin
                    if (i_reg == j_reg) trace_reg <= trace_reg + 128'(sat64(pv_round));
                    acc_reg <= '0;
                    l_reg <= '0;
                    if (j_reg == n_reg - 1'b1) begin
                        j_reg <= '0;
                        i_reg <= i_reg + 1'b1;
                    end else j_reg <= j_reg + 1'b1;
                end else acc_reg <= acc_reg + prod_hi;
            end
            ST_PWR: begin
                neg_reg <= trace_reg[127];
                num_reg <= (trace_reg[127] ? -trace_reg : trace_reg) + 128'(k_reg >> 1);
                rem_reg <= '0; bit_reg <= '0;
            end
            ST_DIVI: ;
            ST_DIV: begin
                bit_reg <= bit_reg + 1'b1;
                if (!trial[127]) begin
                    rem_reg <= trial;
                    num_reg <= {num_reg[126:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[126:0], num_reg[127]};
                    num_reg <= {num_reg[126:0], 1'b0};
                end
                if (bit_reg == 7'd127) begin
                    i_reg <= '0; j_reg <= '0; l_reg <= '0;
                end
            end
            ST_DIAG: begin
                if (l_reg == 0) begin
                    c_reg <= c_new;
                    coeff_reg[n_reg - k_reg] <= c_new;
                    l_reg <= KW'(1);
                end else if (i_reg == n_reg) begin
                    i_reg <= '0; j_reg <= '0; l_reg <= '0;
                    k_reg <= k_reg + 1'b1;
                    trace_reg <= '0;
                end else if (j_reg == n_reg - 1'b1) begin
                    j_reg <= '0; i_reg <= i_reg + 1'b1;
                end else j_reg <= j_reg + 1'b1;
            end
            ST_EMIT: if (m_tready) p_reg <= p_reg + 1'b1;
            default: ;
        endcase
    end
endmodule

/* hdl/cpe_ram.sv */
// Generic single-port-write RAM with registered read.
module cpe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

/* hdl/cpe_checker.sv */
// Port-level checker for the characteristic polynomial engine.
module cpe_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic m_tlast,
    input logic cfg_ready
);
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input ready while emitting");
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready == s_tready) else $error("config ready mismatch");
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid) else $error("output after last");
endmodule

bind characteristic_polynomial_engine_unit cpe_checker u_chk (.aclk, .aresetn,
    .s_tready, .m_tvalid, .m_tready, .m_tlast, .cfg_ready);

/* tb/cpe_coeff_checker.sv */
// Checker: tracks loaded matrix and order, predicts the coefficients and compares.
module cpe_coeff_checker
    import cpe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [3:0]         idx;
        logic signed [63:0] value;
        logic               last;
    } coeff_t;

    coeff_t             coeff_q[$];
    logic signed [31:0] mat_a[8][8];
    logic [3:0]         order_reg;

    assign pending = coeff_q.size();

    function automatic logic signed [63:0] clip64(input logic signed [127:0] v);
        if (v > $signed({64'd0, S64Max})) return S64Max;
        if (v < $signed({{64{1'b1}}, S64Min})) return S64Min;
        return v[63:0];
    endfunction

    function automatic logic signed [127:0] sx(input logic signed [63:0] v);
        return {{64{v[63]}}, v};
    endfunction

    function automatic void predict_coeffs();
        int                  n;
        logic signed [63:0]  w[8][8];
        logic signed [63:0]  p[8][8];
        logic signed [63:0]  c;
        logic signed [63:0]  coef[9];
        logic signed [127:0] acc, tr, mag;
        coeff_t              r;
        n = (order_reg == 0) ? 1 : (order_reg > 8) ? 8 : int'(order_reg);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                w[i][j] = (i == j) ? Q32One : 64'sd0;
        coef[n] = Q32One;
        for (int k = 1; k <= n; k++) begin
            tr = 0;
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++) begin
                    acc = 0;
                    for (int l = 0; l < n; l++)
                        acc = acc + {{96{mat_a[i][l][31]}}, mat_a[i][l]} * sx(w[l][j]);
                    acc = acc + 128'sd32768;
                    acc = acc >>> 16;
                    p[i][j] = clip64(acc);
                end
            for (int i = 0; i < n; i++)
                tr = tr + sx(p[i][i]);
            mag = (tr < 0) ? -tr : tr;
            mag = mag + k / 2;
            mag = mag / k;
            if (tr >= 0)
                mag = -mag;
            c = clip64(mag);
            coef[n - k] = c;
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                    w[i][j] = (i == j) ? clip64(sx(p[i][j]) + sx(c)) : p[i][j];
        end
        for (int q = 0; q <= n; q++) begin
            r.idx = 4'(q);
            r.value = coef[q];
            r.last = (q == n);
            coeff_q.push_back(r);
        end
    endfunction

    always @(posedge aclk) begin
        coeff_t e;
        if (!aresetn) begin
            order_reg <= 4'd1;
            errors <= 0;
            coeff_q.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                order_reg <= cfg_data;
            if (s_tvalid && s_tready) begin
                mat_a[s_tdata[2:0]][s_tdata[5:3]] = s_tdata[37:6];
                if (s_tlast)
                    predict_coeffs();
            end
            if (m_tvalid && m_tready) begin
                if (coeff_q.size() == 0) begin
                    $display("%0t: unexpected coefficient idx=%0d value=%h last=%b",
                             $realtime, m_tdata[3:0], m_tdata[67:4], m_tlast);
                    errors <= errors + 1;
                end else begin
                    e = coeff_q.pop_front();
                    if (e.idx !== m_tdata[3:0] || e.value !== m_tdata[67:4]
                            || e.last !== m_tlast) begin
                        $display({"%0t: mismatch exp idx=%0d value=%h last=%b, ",
                                  "got idx=%0d value=%h last=%b"},
                                 $realtime, e.idx, e.value, e.last,
                                 m_tdata[3:0], m_tdata[67:4], m_tlast);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

/* tb/tb_characteristic_polynomial_engine_unit.sv */
// Testbench top: drives matrix loads and order writes, gives the verdict.
module tb_characteristic_polynomial_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QuietLimit = 100000;
    localparam int ItemTarget = 420;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;
    int          errors;
    int          pending;
    int          quiet;
    int          items_sent;
    bit          no_idle;
    bit          written[8][8];

    characteristic_polynomial_engine_unit dut (.*);

    cpe_coeff_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QuietLimit) begin
                $display("** characteristic_polynomial_engine_unit: FAILED **");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial begin
        int len;
        m_tready = 1'b0;
        forever begin
            len = $urandom_range(1, 12);
            repeat (len) begin
                @(negedge aclk);
                m_tready = 1'b1;
            end
            len = pick_gap();
            repeat (len) begin
                @(negedge aclk);
                m_tready = 1'b0;
            end
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'd0;
            default: return 32'($signed($urandom_range(0, 262143)) - 131072);
        endcase
    endfunction

    task automatic send_elem(input int row, input int col, input logic [31:0] v,
                             input bit last);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = {2'b00, v, 3'(col), 3'(row)};
        s_tlast = last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        written[row][col] = 1'b1;
        items_sent++;
    endtask

    task automatic settle_and_config(input logic [3:0] order);
        @(negedge aclk);
        s_tvalid = 1'b0;
        s_tlast = 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge aclk);
        cfg_data = order;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_random(input logic [3:0] order);
        int n, cnt;
        n = (order == 0) ? 1 : (order > 8) ? 8 : int'(order);
        settle_and_config(order);
        no_idle = ($urandom_range(0, 3) == 0);
        cnt = $urandom_range(0, n * n);
        repeat (cnt) begin
            if ($urandom_range(0, 4) == 0)
                send_elem($urandom_range(0, 7), $urandom_range(0, 7), pick_value(), 1'b0);
            else
                send_elem($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                          pick_value(), 1'b0);
        end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (!written[i][j])
                    send_elem(i, j, pick_value(), 1'b0);
        if ($urandom_range(0, 3) == 0)
            send_elem($urandom_range(0, 7), $urandom_range(0, 7), pick_value(), 1'b1);
        else
            send_elem($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                      pick_value(), 1'b1);
    endtask

    initial begin
        int r;
        logic [3:0] order;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 4'd0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        items_sent = 0;
        no_idle = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // order zero behaves as one; load extremes and an unused corner element
        settle_and_config(4'd0);
        send_elem(0, 0, 32'h7FFF_FFFF, 1'b1);
        send_elem(7, 7, 32'h8000_0000, 1'b0);
        send_elem(0, 0, 32'h8000_0000, 1'b1);
        send_elem(0, 0, 32'h0000_0000, 1'b1);
        settle_and_config(4'd2);
        send_elem(0, 0, 32'h0001_0000, 1'b0);
        send_elem(0, 1, 32'h7FFF_FFFF, 1'b0);
        send_elem(1, 0, 32'h8000_0000, 1'b0);
        send_elem(1, 1, 32'hFFFF_0000, 1'b1);
        send_elem(1, 1, 32'hFFFF_FFFF, 1'b1);
        run_random(4'd15);
        run_random(4'd8);
        run_random(4'd1);

        while (items_sent < ItemTarget) begin
            r = $urandom_range(0, 19);
            if (r < 12) order = 4'($urandom_range(1, 4));
            else if (r < 18) order = 4'($urandom_range(5, 8));
            else order = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
            run_random(order);
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (20) @(negedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("** characteristic_polynomial_engine_unit: PASSED **");
        end else begin
            $display("** characteristic_polynomial_engine_unit: FAILED **");
        end
        $finish;
    end
endmodule

/* characteristic_polynomial_engine_unit.f */
hdl/cpe_pkg.sv
hdl/cpe_ram.sv
hdl/characteristic_polynomial_engine_unit.sv
hdl/cpe_checker.sv
tb/cpe_coeff_checker.sv
tb/tb_characteristic_polynomial_engine_unit.sv
